// File: rtl/emht_pkg.sv
// Shared types and constants for the edge midpoint hash table.
`default_nettype none
package emht_pkg;

    localparam int VTX_W           = 14;
    localparam int EDGE_W          = 2 * VTX_W;
    localparam int HOME_W          = 16;
    localparam int TABLE_SLOTS_DEF = 32768;
    localparam int INDEX_BITS_DEF  = 14;
    localparam int MIN_SLOT_BITS   = 4;

    localparam logic [3:0]       SLOT_BITS_RST = 4'd15;
    localparam logic [VTX_W-1:0] FIRST_NEW_RST = 14'd12;

    // Configuration register indexes
    localparam logic [0:0] CFG_SLOT_BITS = 1'b0;
    localparam logic [0:0] CFG_FIRST_NEW = 1'b1;

    // Commands (tuser on the input side)
    localparam logic [1:0] CMD_FIND        = 2'd0;
    localparam logic [1:0] CMD_CLEAR       = 2'd1;
    localparam logic [1:0] CMD_CLEAR_RELOAD = 2'd2;

    // Result status (tuser on the output side)
    localparam logic [1:0] ST_ADDED     = 2'd0;
    localparam logic [1:0] ST_PRESENT   = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EXHAUSTED = 2'd3;

    // Golden-ratio multiplier, split into 32-bit halves
    localparam logic [31:0] HASH_MULT_HI = 32'h9E37_79B9;
    localparam logic [31:0] HASH_MULT_LO = 32'h7F4A_7C15;

    typedef struct packed {
        logic             start;
        logic [VTX_W-1:0] lo;
        logic [VTX_W-1:0] hi;
    } hash_req_t;

    typedef struct packed {
        logic              done;
        logic [HOME_W-1:0] home;
    } hash_rsp_t;

endpackage
`default_nettype wire

// File: rtl/edge_midpoint_hash_table.sv
// Each probe is one read and one compare on the single-port slot memory; the hash takes
// three passes through one shared multiplier. One command is in flight at a time, so a
// new beat is not taken until the last result has been loaded into the output register.
// Clear commands sweep all 2^SLOT_AW slots of the memory (32768 by default), one per cycle, then reply.
// Reset (aresetn low, synchronous) runs the same sweep; s_tready stays low until it ends.
`default_nettype none
module edge_midpoint_hash_table #(
    parameter int TABLE_SLOTS = emht_pkg::TABLE_SLOTS_DEF,
    parameter int INDEX_BITS  = emht_pkg::INDEX_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [13:0] cfg_wdata,
    // Command stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [13:0] vertex_a, [27:14] vertex_b, [31:28] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [13:0] midpoint_index, [15:14] zero
    output logic      [1:0]  m_tuser    // [1:0] status
);

    localparam int VTX_W   = emht_pkg::VTX_W;
    localparam int CLOG    = $clog2(TABLE_SLOTS);
    // Slots in use are a power of two; a table size that is not one loses its tail.
    localparam int SLOT_AW = ((1 << CLOG) == TABLE_SLOTS) ? CLOG : CLOG - 1;
    localparam int DATA_W  = 1 + emht_pkg::EDGE_W + INDEX_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SWEEP = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CMP   = 3'd4;
    localparam logic [2:0] S_REPLY = 3'd5;

    // Control state
    logic [2:0]           state_reg, state_next;
    logic                 boot_reg, boot_next;
    logic [SLOT_AW-1:0]   sweep_addr_reg, sweep_addr_next;
    logic [SLOT_AW:0]     probe_cnt_reg, probe_cnt_next;
    logic [INDEX_BITS:0]  next_vertex_reg, next_vertex_next;
    logic [3:0]           slot_bits_reg;
    logic [VTX_W-1:0]     first_new_index_reg;
    logic                 m_tvalid_reg, m_tvalid_next;

    // Payload
    logic [VTX_W-1:0]     lo_reg, lo_next;
    logic [VTX_W-1:0]     hi_reg, hi_next;
    logic [SLOT_AW-1:0]   pos_reg, pos_next;
    logic [VTX_W-1:0]     res_mid_reg, res_mid_next;
    logic [1:0]           res_status_reg, res_status_next;
    logic [VTX_W-1:0]     m_mid_reg, m_mid_next;
    logic [1:0]           m_status_reg, m_status_next;

    logic                 in_beat;
    logic [VTX_W-1:0]     vtx_a, vtx_b;
    logic [4:0]           eff_bits;
    logic [SLOT_AW:0]     probe_lim;
    logic [SLOT_AW-1:0]   slot_mask;
    logic [INDEX_BITS:0]  reload_val;

    emht_pkg::hash_req_t  hash_req;
    emht_pkg::hash_rsp_t  hash_rsp;

    logic                 mem_we;
    logic [SLOT_AW-1:0]   mem_addr;
    logic [DATA_W-1:0]    mem_wdata;
    logic [DATA_W-1:0]    mem_rdata;
    logic                 rd_valid;
    logic [emht_pkg::EDGE_W-1:0] rd_edge;
    logic [INDEX_BITS-1:0] rd_mid;

    assign vtx_a      = s_tdata[13:0];
    assign vtx_b      = s_tdata[27:14];
    assign s_tready   = (state_reg == S_IDLE);
    assign in_beat    = s_tvalid && s_tready;
    assign reload_val = (INDEX_BITS + 1)'(INDEX_BITS'(first_new_index_reg));

    // Clamp slot_bits between MIN_SLOT_BITS and what the memory holds; the mask and probe limit follow from it.
    always_comb begin
        if (slot_bits_reg < 4'(emht_pkg::MIN_SLOT_BITS)) begin
            eff_bits = 5'(emht_pkg::MIN_SLOT_BITS);
        end else if ({1'b0, slot_bits_reg} > 5'(SLOT_AW)) begin
            eff_bits = 5'(SLOT_AW);
        end else begin
            eff_bits = {1'b0, slot_bits_reg};
        end
    end
    assign probe_lim = (SLOT_AW + 1)'(1) << eff_bits;
    assign slot_mask = SLOT_AW'(probe_lim - (SLOT_AW + 1)'(1));

    // Slot entry: {valid, edge, midpoint}
    assign rd_mid   = mem_rdata[INDEX_BITS-1:0];
    assign rd_edge  = mem_rdata[INDEX_BITS +: emht_pkg::EDGE_W];
    assign rd_valid = mem_rdata[DATA_W-1];

    assign hash_req.start = in_beat && (s_tuser == emht_pkg::CMD_FIND);
    assign hash_req.lo    = lo_reg;
    assign hash_req.hi    = hi_reg;

    emht_hash u_hash (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (hash_req),
        .rsp     (hash_rsp)
    );

    emht_table #(
        .ADDR_W (SLOT_AW),
        .DATA_W (DATA_W)
    ) u_table (
        .aclk    (aclk),
        .we      (mem_we),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .rd_data (mem_rdata)
    );

    // Sequencer
    always_comb begin
        state_next       = state_reg;
        boot_next        = boot_reg;
        sweep_addr_next  = sweep_addr_reg;
        probe_cnt_next   = probe_cnt_reg;
        next_vertex_next = next_vertex_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        pos_next         = pos_reg;
        res_mid_next     = res_mid_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_mid_next       = m_mid_reg;
        m_status_next    = m_status_reg;
        mem_we           = 1'b0;
        mem_addr         = pos_reg;
        mem_wdata        = {1'b1, lo_reg, hi_reg, next_vertex_reg[INDEX_BITS-1:0]};

        // Drop the result beat once the sink takes it.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    lo_next         = (vtx_a < vtx_b) ? vtx_a : vtx_b;
                    hi_next         = (vtx_a < vtx_b) ? vtx_b : vtx_a;
                    res_mid_next    = '0;
                    res_status_next = emht_pkg::ST_ADDED;
                    case (s_tuser)
                        emht_pkg::CMD_FIND: begin
                            state_next = S_HASH;
                        end
                        emht_pkg::CMD_CLEAR: begin
                            sweep_addr_next = '0;
                            state_next      = S_SWEEP;
                        end
                        emht_pkg::CMD_CLEAR_RELOAD: begin
                            sweep_addr_next  = '0;
                            next_vertex_next = reload_val;
                            state_next       = S_SWEEP;
                        end
                        default: begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end
            S_SWEEP: begin
                // Write an empty entry per cycle across every slot of the memory.
                mem_we          = 1'b1;
                mem_addr        = sweep_addr_reg;
                mem_wdata       = '0;
                sweep_addr_next = sweep_addr_reg + SLOT_AW'(1);
                if (&sweep_addr_reg) begin
                    boot_next  = 1'b0;
                    state_next = boot_reg ? S_IDLE : S_REPLY;
                end
            end
            S_HASH: begin
                if (hash_rsp.done) begin
                    pos_next       = SLOT_AW'(hash_rsp.home) & slot_mask;
                    probe_cnt_next = '0;
                    state_next     = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (!rd_valid) begin
                    if (next_vertex_reg[INDEX_BITS]) begin
                        res_status_next = emht_pkg::ST_EXHAUSTED;
                    end else begin
                        mem_we           = 1'b1;
                        res_mid_next     = VTX_W'(next_vertex_reg[INDEX_BITS-1:0]);
                        res_status_next  = emht_pkg::ST_ADDED;
                        next_vertex_next = next_vertex_reg + (INDEX_BITS + 1)'(1);
                    end
                    state_next = S_REPLY;
                end else if (rd_edge == {lo_reg, hi_reg}) begin
                    res_mid_next    = VTX_W'(rd_mid);
                    res_status_next = emht_pkg::ST_PRESENT;
                    state_next      = S_REPLY;
                end else begin
                    // Advance to the next slot, wrapping within the mask.
                    pos_next       = (pos_reg + SLOT_AW'(1)) & slot_mask;
                    probe_cnt_next = probe_cnt_reg + (SLOT_AW + 1)'(1);
                    if (probe_cnt_next == probe_lim) begin
                        res_status_next = emht_pkg::ST_FULL;
                        state_next      = S_REPLY;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_REPLY: begin
                // Hold until the output register is free, then load the beat.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_mid_next    = res_mid_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= S_SWEEP;
            boot_reg            <= 1'b1;
            sweep_addr_reg      <= '0;
            probe_cnt_reg       <= '0;
            next_vertex_reg     <= (INDEX_BITS + 1)'(INDEX_BITS'(emht_pkg::FIRST_NEW_RST));
            slot_bits_reg       <= emht_pkg::SLOT_BITS_RST;
            first_new_index_reg <= emht_pkg::FIRST_NEW_RST;
            m_tvalid_reg        <= 1'b0;
        end else begin
            state_reg       <= state_next;
            boot_reg        <= boot_next;
            sweep_addr_reg  <= sweep_addr_next;
            probe_cnt_reg   <= probe_cnt_next;
            next_vertex_reg <= next_vertex_next;
            m_tvalid_reg    <= m_tvalid_next;
            if (cfg_we && (cfg_addr == emht_pkg::CFG_SLOT_BITS)) begin
                slot_bits_reg <= cfg_wdata[3:0];
            end
            if (cfg_we && (cfg_addr == emht_pkg::CFG_FIRST_NEW)) begin
                first_new_index_reg <= cfg_wdata;
            end
        end
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        pos_reg        <= pos_next;
        res_mid_reg    <= res_mid_next;
        res_status_reg <= res_status_next;
        m_mid_reg      <= m_mid_next;
        m_status_reg   <= m_status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_mid_reg};
    assign m_tuser  = m_status_reg;

`ifndef SYNTH
    // One command at a time: after an input beat the block is busy.
    a_busy_after_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        in_beat |=> !s_tready)
        else $error("input accepted on back-to-back cycles");

    // The counter stops exactly at the exhaustion mark.
    a_counter_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        next_vertex_reg[INDEX_BITS] |-> (next_vertex_reg[INDEX_BITS-1:0] == '0))
        else $error("vertex counter ran past the index space");

    // The hash only finishes while the sequencer waits for it.
    a_hash_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        hash_rsp.done |-> (state_reg == S_HASH))
        else $error("hash result outside hash state");

    // A probe never starts once every slot in use has been visited.
    a_probe_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_READ) |-> (probe_cnt_reg < probe_lim))
        else $error("probe count beyond slots in use");
`endif

endmodule
`default_nettype wire

// File: rtl/emht_hash.sv
// Multiplicative edge hash built on one shared 15x32 multiplier over three steps.
`default_nettype none
module emht_hash (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire emht_pkg::hash_req_t req,
    output emht_pkg::hash_rsp_t      rsp
);

    logic                        run_reg, run_next;
    logic [1:0]                  step_reg, step_next;
    logic [emht_pkg::HOME_W-1:0] acc_reg, acc_next;
    logic                        done_reg, done_next;

    logic [14:0]                 mul_a;
    logic [31:0]                 mul_b;
    logic [46:0]                 prod;
    logic [emht_pkg::HOME_W-1:0] term;
    logic [14:0]                 hi_inc;

    // Key is lo*2^32 + (hi+1); bits 47:32 of key*C split into three partial terms.
    assign hi_inc = 15'(req.hi) + 15'd1;
    assign prod   = 47'(mul_a) * 47'(mul_b);

    always_comb begin
        case (step_reg)
            2'd0: begin
                mul_a = hi_inc;
                mul_b = emht_pkg::HASH_MULT_LO;
                term  = {1'b0, prod[46:32]};
            end
            2'd1: begin
                mul_a = {1'b0, req.lo};
                mul_b = emht_pkg::HASH_MULT_LO;
                term  = prod[15:0];
            end
            2'd2: begin
                mul_a = hi_inc;
                mul_b = emht_pkg::HASH_MULT_HI;
                term  = prod[15:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
                term  = '0;
            end
        endcase
    end

    always_comb begin
        run_next  = run_reg;
        step_next = step_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (req.start) begin
            run_next  = 1'b1;
            step_next = 2'd0;
            acc_next  = '0;
        end else if (run_reg) begin
            acc_next  = acc_reg + term;
            step_next = step_reg + 2'd1;
            if (step_reg == 2'd2) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            step_reg <= 2'd0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            step_reg <= step_next;
            done_reg <= done_next;
        end
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.home = acc_reg;

endmodule
`default_nettype wire

// File: rtl/emht_table.sv
// Single-port slot memory with registered read data.
`default_nettype none
module emht_table #(
    parameter int ADDR_W = 15,
    parameter int DATA_W = 43
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [DATA_W-1:0] wdata,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] slot_mem [2**ADDR_W];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            slot_mem[addr] <= wdata;
        end
        rd_data_reg <= slot_mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

// File: tb/sv/edge_midpoint_hash_table_checker.sv
// Scoreboard for the edge midpoint hash table: mirrors the slot store and checks each result beat.
module edge_midpoint_hash_table_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_addr,
    input  wire logic [13:0] cfg_wdata,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,   // [13:0] vertex_a, [27:14] vertex_b, [31:28] zero
    input  wire logic [1:0]  s_tuser,   // [1:0] cmd
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [15:0] m_tdata,   // [13:0] midpoint_index, [15:14] zero
    input  wire logic [1:0]  m_tuser,   // [1:0] status
    output int               mismatches,
    output int               pending,
    output int               n_added,
    output int               n_present,
    output int               n_full,
    output int               n_exhausted
);
    import emht_pkg::*;

    localparam int          SLOTS    = TABLE_SLOTS_DEF;
    localparam int          MAX_BITS = $clog2(TABLE_SLOTS_DEF);
    localparam logic [63:0] GOLDEN   = {HASH_MULT_HI, HASH_MULT_LO};

    typedef struct packed {
        logic [VTX_W-1:0] midpoint;
        logic [1:0]       status;
    } edge_result_t;

    bit                slot_used [SLOTS];
    logic [EDGE_W-1:0] slot_key  [SLOTS];
    logic [VTX_W-1:0]  slot_mid  [SLOTS];
    logic [VTX_W:0]    next_free;
    logic [3:0]        slot_bits_q;
    logic [VTX_W-1:0]  first_new_q;
    edge_result_t      awaited [$];
    edge_result_t      fresh, oldest;
    int                fail_count, added_count, present_count, full_count, exhausted_count;

    function automatic void wipe_slots();
        int i;
        for (i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    endfunction

    // Find the edge or give it the next free index; clears empty the store.
    function automatic edge_result_t find_or_add(input logic [1:0] cmd,
                                                 input logic [VTX_W-1:0] va,
                                                 input logic [VTX_W-1:0] vb);
        edge_result_t     res;
        logic [VTX_W-1:0] lo, hi;
        logic [63:0]      key, prod;
        logic [31:0]      mask, pos;
        int               eff_bits, probe;
        bit               settled;
        res.midpoint = '0;
        res.status   = ST_ADDED;
        case (cmd)
            CMD_CLEAR: wipe_slots();
            CMD_CLEAR_RELOAD: begin
                wipe_slots();
                next_free = {1'b0, first_new_q};
            end
            CMD_FIND: begin
                lo = (va < vb) ? va : vb;
                hi = (va < vb) ? vb : va;
                key = ({50'd0, lo} << 32) | {50'd0, hi};
                key = key + 64'd1;
                prod = key * GOLDEN;
                eff_bits = int'(slot_bits_q);
                if (eff_bits < MIN_SLOT_BITS) eff_bits = MIN_SLOT_BITS;
                if (eff_bits > MAX_BITS) eff_bits = MAX_BITS;
                mask = (32'd1 << eff_bits) - 32'd1;
                pos = prod[63:32] & mask;
                settled = 1'b0;
                for (probe = 0; probe <= mask && !settled; probe++) begin
                    if (!slot_used[pos]) begin
                        settled = 1'b1;
                        if (next_free[VTX_W]) begin
                            res.status = ST_EXHAUSTED;
                        end else begin
                            slot_used[pos] = 1'b1;
                            slot_key[pos]  = {lo, hi};
                            slot_mid[pos]  = next_free[VTX_W-1:0];
                            res.midpoint   = next_free[VTX_W-1:0];
                            next_free      = next_free + (VTX_W + 1)'(1);
                        end
                    end else if (slot_key[pos] == {lo, hi}) begin
                        settled      = 1'b1;
                        res.midpoint = slot_mid[pos];
                        res.status   = ST_PRESENT;
                    end else begin
                        pos = (pos + 32'd1) & mask;
                    end
                end
                if (!settled) res.status = ST_FULL;
            end
            default: ;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string field, input int got, input int want);
        $display("checker: %0s mismatch at %0t: got %0d, expected %0d", field, $time, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            wipe_slots();
            slot_bits_q     = SLOT_BITS_RST;
            first_new_q     = FIRST_NEW_RST;
            next_free       = {1'b0, FIRST_NEW_RST};
            awaited.delete();
            fail_count      = 0;
            added_count     = 0;
            present_count   = 0;
            full_count      = 0;
            exhausted_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_SLOT_BITS: slot_bits_q = cfg_wdata[3:0];
                    CFG_FIRST_NEW: first_new_q = cfg_wdata[VTX_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                fresh = find_or_add(s_tuser, s_tdata[VTX_W-1:0], s_tdata[2*VTX_W-1:VTX_W]);
                awaited.push_back(fresh);
                if (s_tuser == CMD_FIND) begin
                    case (fresh.status)
                        ST_ADDED:     added_count++;
                        ST_PRESENT:   present_count++;
                        ST_FULL:      full_count++;
                        ST_EXHAUSTED: exhausted_count++;
                        default: ;
                    endcase
                end
            end
            if (m_tvalid && m_tready) begin
                if (awaited.size() == 0) begin
                    report_mismatch("unrequested result", int'(m_tdata[VTX_W-1:0]), 0);
                end else begin
                    oldest = awaited.pop_front();
                    if (m_tdata[VTX_W-1:0] !== oldest.midpoint)
                        report_mismatch("midpoint_index", int'(m_tdata[VTX_W-1:0]),
                                        int'(oldest.midpoint));
                    if (m_tuser !== oldest.status)
                        report_mismatch("status", int'(m_tuser), int'(oldest.status));
                end
            end
        end
        pending     <= awaited.size();
        mismatches  <= fail_count;
        n_added     <= added_count;
        n_present   <= present_count;
        n_full      <= full_count;
        n_exhausted <= exhausted_count;
    end

endmodule

// File: tb/sv/edge_midpoint_hash_table_test.sv
// Top of the edge midpoint hash table testbench: clock, reset, stimulus and verdict.
module edge_midpoint_hash_table_test;
    import emht_pkg::*;

    // The block replies to command 3 without touching the table; give it a name for the noise beats.
    localparam logic [1:0]       CMD_UNUSED = 2'd3;
    localparam logic [VTX_W-1:0] VTX_MAX    = {VTX_W{1'b1}};
    // A clear sweeps 32768 slots with no beat moving, plus a receiver stall and a
    // sender gap on top; allow several times that before calling the run hung.
    localparam int IDLE_LIMIT = 150000;

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        cfg_we    = 1'b0;
    logic [0:0]  cfg_addr  = CFG_SLOT_BITS;
    logic [13:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;     // [13:0] vertex_a, [27:14] vertex_b, [31:28] zero
    logic [1:0]  s_tuser   = CMD_FIND; // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;            // [13:0] midpoint_index, [15:14] zero
    logic [1:0]  m_tuser;            // [1:0] status

    int mismatches, pending, n_added, n_present, n_full, n_exhausted;
    int items_sent   = 0;
    int noise_sent   = 0;
    int clears_sent  = 0;
    int idle_cycles  = 0;
    int ready_left   = 0;
    int ready_roll   = 0;
    int burst_left   = 0;
    int clear_budget = 6;   // random clears are slow; keep them few
    logic [EDGE_W-1:0] recent_edges [$];

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    edge_midpoint_hash_table dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    edge_midpoint_hash_table_checker u_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .mismatches  (mismatches),
        .pending     (pending),
        .n_added     (n_added),
        .n_present   (n_present),
        .n_full      (n_full),
        .n_exhausted (n_exhausted)
    );

    // Receiver back-pressure: long open stretches, short blips, now and then a long stall.
    always @(posedge aclk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            ready_roll = $urandom_range(0, 99);
            if (ready_roll < 15) begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(40, 200);
            end else if (ready_roll < 60) begin
                m_tready   <= 1'b1;
                ready_left <= $urandom_range(0, 7);
            end else if (ready_roll < 92) begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(0, 2);
            end else begin
                m_tready   <= 1'b0;
                ready_left <= $urandom_range(10, 40);
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("edge_midpoint_hash_table_test: errors");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offer one command beat, hold it until taken, then maybe idle a while.
    task automatic send_command(input logic [1:0] cmd, input logic [VTX_W-1:0] va,
                                input logic [VTX_W-1:0] vb);
        int gap, roll;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, vb, va};
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        if (cmd == CMD_UNUSED) noise_sent++;
        else items_sent++;
        if (cmd == CMD_CLEAR || cmd == CMD_CLEAR_RELOAD) clears_sent++;
        gap = 0;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 4) burst_left = $urandom_range(20, 60);
            else if (roll < 55) gap = 0;
            else if (roll < 85) gap = $urandom_range(1, 3);
            else if (roll < 97) gap = $urandom_range(4, 10);
            else gap = $urandom_range(20, 60);
        end
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Drop valid and hold off until every outstanding result beat is back.
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // Write both registers back to back; junk rides in the unused slot_bits bits.
    task automatic program_table(input logic [3:0] bits, input logic [VTX_W-1:0] first_word);
        logic [9:0] junk;
        junk = 10'($urandom);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SLOT_BITS;
        cfg_wdata <= {junk, bits};
        @(posedge aclk);
        cfg_addr  <= CFG_FIRST_NEW;
        cfg_wdata <= first_word;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Mesh-like traffic: revisit recent edges in either order, fan out from shared
    // vertices, mix in fresh edges, unused commands and the odd clear.
    task automatic run_mesh(input int items);
        int                done_items, roll;
        logic [EDGE_W-1:0] e;
        logic [VTX_W-1:0]  va, vb;
        done_items = 0;
        while (done_items < items) begin
            roll = $urandom_range(0, 999);
            if (roll < 70) begin
                send_command(CMD_UNUSED, VTX_W'($urandom), VTX_W'($urandom));
            end else begin
                if (roll < 76 && clear_budget > 0) begin
                    clear_budget--;
                    send_command(roll[0] ? CMD_CLEAR : CMD_CLEAR_RELOAD,
                                 VTX_W'($urandom), VTX_W'($urandom));
                end else if (roll < 520 && recent_edges.size() > 0) begin
                    e = recent_edges[$urandom_range(0, recent_edges.size() - 1)];
                    {va, vb} = e;
                    if ($urandom_range(0, 1)) send_command(CMD_FIND, va, vb);
                    else send_command(CMD_FIND, vb, va);
                end else begin
                    va = VTX_W'($urandom);
                    vb = VTX_W'($urandom);
                    if (recent_edges.size() > 0 && $urandom_range(0, 2) == 0) begin
                        e  = recent_edges[$];
                        va = $urandom_range(0, 1) ? e[EDGE_W-1:VTX_W] : e[VTX_W-1:0];
                    end
                    if ($urandom_range(0, 29) == 0) vb = va;
                    if ($urandom_range(0, 19) == 0) va = $urandom_range(0, 1) ? VTX_MAX : '0;
                    recent_edges.push_back({va, vb});
                    if (recent_edges.size() > 48) void'(recent_edges.pop_front());
                    send_command(CMD_FIND, va, vb);
                end
                done_items++;
                if ($urandom_range(0, 99) == 0) settle();
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Defaults after reset: full table, counter at its reset value.
        send_command(CMD_FIND, '0, '0);
        send_command(CMD_FIND, VTX_MAX, VTX_MAX);
        send_command(CMD_FIND, VTX_MAX, '0);
        send_command(CMD_FIND, '0, VTX_MAX);            // same edge, swapped ends
        send_command(CMD_FIND, '0, '0);
        send_command(CMD_FIND, 14'h2AAA, 14'h1555);
        send_command(CMD_FIND, 14'h1555, 14'h2AAA);
        send_command(CMD_UNUSED, VTX_MAX, VTX_MAX);     // must change nothing
        send_command(CMD_CLEAR, '0, '0);                // empty slots, keep counter
        send_command(CMD_FIND, '0, '0);

        // Reload the counter to the last index: one add, then the index space runs out.
        settle();
        program_table(4'd15, VTX_MAX);
        send_command(CMD_CLEAR_RELOAD, '0, '0);
        send_command(CMD_FIND, 14'd5, 14'd9);
        send_command(CMD_FIND, 14'd7, 14'd8);
        send_command(CMD_FIND, 14'd9, 14'd5);           // present edges are still found
        send_command(CMD_FIND, VTX_MAX, VTX_MAX);

        // slot_bits below the minimum acts as 16 slots: the table fills fast.
        settle();
        program_table(4'd0, '0);
        send_command(CMD_CLEAR_RELOAD, '0, '0);
        run_mesh(120);

        // Widen to the full table without clearing; old entries stay where they were.
        settle();
        program_table(4'd15, VTX_W'($urandom));
        run_mesh(250);

        // Narrow to the smallest legal mask, again without a clear.
        settle();
        program_table(4'd4, VTX_W'($urandom));
        run_mesh(150);

        // Start the counter near the top so the index space runs out mid-phase.
        settle();
        program_table(4'd9, VTX_MAX - 14'd40);
        send_command(CMD_CLEAR_RELOAD, '0, '0);
        run_mesh(200);

        settle();
        program_table(4'd12, VTX_W'($urandom));
        send_command(CMD_CLEAR_RELOAD, '0, '0);
        run_mesh(180);

        // Drain, then give stray beats a chance to show up.
        settle();
        repeat (40) @(posedge aclk);

        $display("Run covered %0d commands (%0d clears) and %0d ignored command beats.",
                 items_sent, clears_sent, noise_sent);
        $display("Finds: %0d added, %0d present, %0d table full, %0d index space exhausted.",
                 n_added, n_present, n_full, n_exhausted);
        if (mismatches == 0 && pending == 0) begin
            $display("edge_midpoint_hash_table_test: clean");
        end else begin
            $display("edge_midpoint_hash_table_test: errors");
        end
        $finish;
    end

endmodule
